// File: sv/generational_handle_allocator_defines.svh
// Assertion macros shared by the allocator's checker.
// Depends on nothing; included by name where assertions are written.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Implication checked only while reset is released.
`define GHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gha assertion failed");

// Implication checked on every edge, reset included.
`define GHA_ASSERT_IMP_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("gha assertion failed");

`endif

// File: sv/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Depends on nothing.
`default_nettype none

package gha_pkg;

    localparam int IDW          = 10;   // handle id field width
    localparam int GENW         = 16;   // generation field width on the ports
    localparam int CAPACITY_DEF = 1024;
    localparam int GEN_BITS_DEF = 16;

    // operation codes (any other code behaves as a check)
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

    typedef struct packed {
        logic [1:0]      operation;
        logic [IDW-1:0]  handle_id;
        logic [GENW-1:0] handle_generation;
    } t_cmd;

    typedef struct packed {
        logic [IDW-1:0]  result_id;
        logic [GENW-1:0] result_generation;
        logic            alive;
        logic [1:0]      status;
    } t_result;

endpackage

`default_nettype wire

// File: sv/gha_gen_store.sv
// Per-slot generation memory with a clearing sweep after reset and write bypass.
// Depends on nothing outside this file.
`default_nettype none

module gha_gen_store #(
    parameter int CAPACITY = 1024,
    parameter int GEN_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  wire logic [GEN_BITS-1:0]         i_wr_data,
    output logic      [GEN_BITS-1:0]         o_rd_data,
    output logic                             o_clearing
);

    localparam int AW = $clog2(CAPACITY);

    logic [GEN_BITS-1:0] r_mem [CAPACITY];
    logic [AW-1:0]       r_clr;
    logic                r_clearing;
    logic [GEN_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(CAPACITY - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // one write port, one registered read port; a same-address write wins
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr_data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// File: sv/generational_handle_allocator.sv
// Top level of the generational handle allocator.
// Depends on gha_pkg and gha_gen_store.
`default_nettype none

// Generational handle allocator.
// Command channel: an item (i_cmd) is taken at a rising edge with start high
// and busy low. Operations: create a handle, destroy a handle, check a handle.
// Result channel: each item gives one result item on o_result, shown for one
// cycle with o_strobe high; the receiver cannot stall, so nothing is held back.
// Throughput: one item every cycle once busy is low.
// The item's memory reads (generation store, the free-stack entry below the
// top) are issued at the accepting edge; the next cycle decides, writes back
// and registers the result. A following item's reads are bypassed from that
// write, and its create slot comes from the updated stack/fresh counters.
// The free stack keeps its top entry in a register, the rest in a memory.
// Reset: the generation store is swept to zero, one slot per cycle, and busy
// stays high until the sweep is done. The free stack is emptied and the
// fresh-id counter set to 1 at once (id 0 is never handed out as a fresh id).
// No room: create with no free and no fresh id, or a destroy onto a full stack.
module generational_handle_allocator #(
    parameter int CAPACITY = gha_pkg::CAPACITY_DEF,
    parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire gha_pkg::t_cmd   i_cmd,
    output logic                 o_strobe,
    output gha_pkg::t_result     o_result
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int IDW = gha_pkg::IDW;
    localparam int EW  = (IDW > AW + 1) ? IDW : AW + 1;   // width for id range compares

    // committed allocator state
    logic [AW:0]           r_depth, n_depth;    // free stack depth
    logic [AW-1:0]         r_top, n_top;        // free stack top entry
    logic [AW:0]           r_fresh, n_fresh;    // next fresh id

    // execute stage
    logic                  r_x_valid;
    logic [1:0]            r_x_op;
    logic [IDW-1:0]        r_x_id;
    logic [GEN_BITS-1:0]   r_x_gen;
    logic                  r_x_id_ok;
    logic [AW-1:0]         r_stk_rd;            // entry just below the top

    logic                  r_strobe;
    gha_pkg::t_result      r_res, n_res;

    // free stack body (entries below the top)
    logic [AW-1:0]         r_stk [CAPACITY];
    logic                  stk_we;
    logic [AW-1:0]         stk_wa, stk_wd, stk_ra;

    logic                  gen_we;
    logic [AW-1:0]         gen_wa, gen_ra;
    logic [GEN_BITS-1:0]   gen_wd, gen_rd;
    logic                  clearing;

    logic                  accept;
    logic [AW-1:0]         x_addr, a_nid;
    logic                  match;

    assign busy   = clearing;
    assign accept = start && !clearing;
    assign x_addr = AW'(r_x_id);
    assign match  = (gen_rd == r_x_gen);

    // execute: decide, update state, build the result
    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        n_fresh = r_fresh;
        gen_we  = 1'b0;
        gen_wa  = x_addr;
        gen_wd  = gen_rd + 1'b1;
        stk_we  = 1'b0;
        stk_wa  = AW'(r_depth - 1'b1);
        stk_wd  = r_top;
        n_res.result_id         = r_x_id;
        n_res.result_generation = gha_pkg::GENW'(gen_rd);
        n_res.alive             = 1'b0;
        n_res.status            = gha_pkg::ST_OK;
        if (r_x_valid) begin
            if (r_x_op == gha_pkg::OP_CREATE) begin
                n_res.alive = 1'b1;
                if (r_depth != '0) begin
                    n_depth         = r_depth - 1'b1;
                    n_top           = r_stk_rd;
                    n_res.result_id = IDW'(r_top);
                end else if (r_fresh < (AW + 1)'(CAPACITY)) begin
                    n_fresh         = r_fresh + 1'b1;
                    n_res.result_id = IDW'(r_fresh);
                end else begin
                    n_res.result_id         = '0;
                    n_res.result_generation = '0;
                    n_res.alive             = 1'b0;
                    n_res.status            = gha_pkg::ST_NO_ROOM;
                end
            end else if (!r_x_id_ok) begin
                // id outside the store: nothing to look at
                n_res.result_generation = '0;
                if (r_x_op == gha_pkg::OP_DESTROY) begin
                    n_res.status = gha_pkg::ST_DEAD;
                end
            end else if (r_x_op != gha_pkg::OP_DESTROY) begin
                n_res.alive = match;
            end else if (!match) begin
                n_res.status = gha_pkg::ST_DEAD;
            end else if (r_depth == (AW + 1)'(CAPACITY)) begin
                n_res.alive  = 1'b1;
                n_res.status = gha_pkg::ST_NO_ROOM;
            end else begin
                n_res.alive             = 1'b1;
                n_res.result_generation = gha_pkg::GENW'(gen_wd);
                gen_we  = 1'b1;
                n_depth = r_depth + 1'b1;
                if (r_depth == '0) begin
                    n_top = x_addr;
                end else if (r_top < x_addr) begin
                    // larger id slides in under the top
                    stk_we = 1'b1;
                    stk_wd = x_addr;
                end else begin
                    stk_we = 1'b1;
                    stk_wd = r_top;
                    n_top  = x_addr;
                end
            end
        end
    end

    // read addresses for the incoming item, from the state it will see
    assign a_nid  = (n_depth != '0) ? n_top : n_fresh[AW-1:0];
    assign gen_ra = (i_cmd.operation == gha_pkg::OP_CREATE) ? a_nid
                                                            : AW'(i_cmd.handle_id);
    assign stk_ra = AW'(n_depth - 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_fresh   <= (AW + 1)'(1);
            r_x_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_fresh   <= n_fresh;
            r_x_valid <= accept;
            r_strobe  <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_res     <= n_res;
        r_x_op    <= i_cmd.operation;
        r_x_id    <= i_cmd.handle_id;
        r_x_gen   <= GEN_BITS'(i_cmd.handle_generation);
        r_x_id_ok <= (EW'(i_cmd.handle_id) < EW'(CAPACITY));
    end

    // free stack memory with write bypass on the read port
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        if (stk_we && (stk_wa == stk_ra)) begin
            r_stk_rd <= stk_wd;
        end else begin
            r_stk_rd <= r_stk[stk_ra];
        end
    end

    gha_gen_store #(
        .CAPACITY (CAPACITY),
        .GEN_BITS (GEN_BITS)
    ) u_gen_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (gen_ra),
        .i_wr_en    (gen_we),
        .i_wr_addr  (gen_wa),
        .i_wr_data  (gen_wd),
        .o_rd_data  (gen_rd),
        .o_clearing (clearing)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

// File: sv/gha_checker.sv
// Port-level checker for the generational handle allocator, with its bind.
// Depends on gha_pkg and generational_handle_allocator_defines.svh.
`default_nettype none
`include "generational_handle_allocator_defines.svh"

module gha_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire gha_pkg::t_cmd    i_cmd,
    input wire logic             o_strobe,
    input wire gha_pkg::t_result o_result
);

    // every result strobe traces back to an accepted item
    `GHA_ASSERT_IMP(a_strobe_has_item, i_clk, i_rst_n, o_strobe, $past(start && !busy, 2))
    // busy comes up straight after reset for the clearing sweep
    `GHA_ASSERT_IMP_ALWAYS(a_busy_after_reset, i_clk, $past(!i_rst_n), busy)
    // no result can come out of the clearing sweep
    `GHA_ASSERT_IMP(a_quiet_while_busy, i_clk, i_rst_n, busy && $past(busy), !o_strobe)
    // a dead handle is never reported alive
    `GHA_ASSERT_IMP(a_dead_not_alive, i_clk, i_rst_n, o_strobe && o_result.status == gha_pkg::ST_DEAD, !o_result.alive)

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
